>>> src/flow_rate_meter_table_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the flow rate meter checker
// ----------------------------------------------------------------------------
`ifndef FLOW_RATE_METER_TABLE_CORE_MACROS_SVH
`define FLOW_RATE_METER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, reset masked
`define FRMT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked
`define FRMT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/frmt_pkg.sv
// ----------------------------------------------------------------------------
// frmt_pkg
// Types and codes of the flow rate meter table.
// ----------------------------------------------------------------------------
package frmt_pkg;

  localparam int unsigned OUT_W      = 48;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 224;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SOURCE_ONLY = 2'd0;
  localparam logic [1:0] REG_FLOW_LIMIT  = 2'd1;
  localparam logic [1:0] REG_IDLE_RELOAD = 2'd2;

  // Item kinds
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_AGE    = 1'b1;

  typedef enum logic [2:0] {
    ST_COUNTED    = 3'd0,
    ST_NEW_FLOW   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_AGED_KEPT  = 3'd3,
    ST_AGED_FREED = 3'd4,
    ST_SLOT_EMPTY = 3'd5
  } frmt_status_e;

  typedef struct packed {
    logic        source_only;
    logic [10:0] flow_limit;
    logic [2:0]  idle_reload;
  } frmt_cfg_t;

  // Item as handed from front to back, key already masked
  typedef struct packed {
    logic        op;
    logic [63:0] key_addr;
    logic [39:0] key_pp;
    logic [15:0] packet_bytes;
    logic [9:0]  slot;
  } frmt_item_t;

  typedef struct packed {
    frmt_status_e       status;
    logic [9:0]         slot_index;
    logic [OUT_W-1:0]   interval_rate;
    logic [OUT_W-1:0]   average_rate;
    logic [15:0]        interval_packets;
    logic [OUT_W-1:0]   flow_bytes;
    logic [OUT_W-1:0]   total_bytes;
  } frmt_result_t;

endpackage

>>> src/frmt_ram.sv
// ----------------------------------------------------------------------------
// frmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/frmt_front.sv
// ----------------------------------------------------------------------------
// frmt_front
// Accept input beats, build the masked flow key, queue items for the back.
// ----------------------------------------------------------------------------
module frmt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frmt_pkg::frmt_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_op_i,
  input  logic [7:0]            in_protocol_i,
  input  logic [31:0]           in_src_addr_i,
  input  logic [15:0]           in_sport_i,
  input  logic [31:0]           in_dst_addr_i,
  input  logic [15:0]           in_dport_i,
  input  logic [15:0]           in_packet_bytes_i,
  input  logic [9:0]            in_slot_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output frmt_pkg::frmt_item_t  q_item_o
);
  import frmt_pkg::*;

  frmt_item_t  fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  frmt_item_t  item;
  logic        push, pop;

  // Mask the key in source-only mode
  always_comb begin
    item.op           = in_op_i;
    item.packet_bytes = in_packet_bytes_i;
    item.slot         = in_slot_i;
    if (cfg_i.source_only) begin
      item.key_addr = {in_src_addr_i, 32'd0};
      item.key_pp   = {in_protocol_i, 32'd0};
    end else begin
      item.key_addr = {in_src_addr_i, in_dst_addr_i};
      item.key_pp   = {in_protocol_i, in_sport_i, in_dport_i};
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = fifo_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> src/frmt_back.sv
// ----------------------------------------------------------------------------
// frmt_back
// Search the flow table, update entries, age slots, hold the result beat.
// ----------------------------------------------------------------------------
module frmt_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  frmt_pkg::frmt_cfg_t    cfg_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  frmt_pkg::frmt_item_t   q_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output frmt_pkg::frmt_result_t out_o
);
  import frmt_pkg::*;

  localparam int unsigned IW  = $clog2(TABLE_DEPTH);
  localparam int unsigned FCW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW  = COUNT_WIDTH;

  typedef struct packed {
    logic          valid;
    logic          started;
    logic [2:0]    idle;
    logic [15:0]   packets;
    logic [CW-1:0] average;
    logic [CW-1:0] prev_bytes;
    logic [CW-1:0] bytes;
    logic [39:0]   proto_ports;
    logic [63:0]   addresses;
  } entry_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_PKT    = 6'b001000,
    S_AGE_RD = 6'b010000,
    S_AGE    = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  frmt_item_t    item_q, item_d;
  logic [IW:0]   iss_q, iss_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          hit_q, hit_d, free_q, free_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  entry_t        word_q, word_d;
  logic [CW-1:0] delta_q, delta_d;
  logic [FCW-1:0] flow_cnt_q, flow_cnt_d;
  logic [CW-1:0] total_q, total_d;
  logic          out_valid_q, out_valid_d;
  frmt_result_t  out_q, out_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic [CW:0]   flow_sum, total_sum, avg_sum;
  logic [CW-1:0] len, flow_new, total_new, avg_new;
  logic          nz, freed;
  entry_t        nw;

  frmt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign q_ready_o   = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Saturating adders for packet updates
  assign len       = CW'(item_q.packet_bytes);
  assign flow_sum  = {1'b0, word_q.bytes} + {1'b0, len};
  assign total_sum = {1'b0, total_q} + {1'b0, len};
  assign flow_new  = flow_sum[CW] ? {CW{1'b1}} : flow_sum[CW-1:0];
  assign total_new = total_sum[CW] ? {CW{1'b1}} : total_sum[CW-1:0];

  // Halving average: floor((avg + rate) / 2), or the rate itself in a flow's first interval
  assign avg_sum = {1'b0, word_q.average} + {1'b0, delta_q};
  assign avg_new = word_q.started ? avg_sum[CW:1] : delta_q;
  assign nz      = (delta_q != '0);
  assign freed   = !nz && (word_q.idle == 3'd0);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    iss_d       = iss_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    word_d      = word_q;
    delta_d     = delta_q;
    flow_cnt_d  = flow_cnt_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    ram_raddr   = iss_q[IW-1:0];
    nw          = word_q;

    unique case (state_q)
      // Sweep the table once after reset, marking every slot free
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == IW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        ram_raddr = IW'(q_item_i.slot);
        if (q_valid_i && q_ready_o) begin
          item_d = q_item_i;
          if (q_item_i.op == OP_PACKET) begin
            iss_d   = '0;
            hit_d   = 1'b0;
            free_d  = 1'b0;
            state_d = S_SCAN;
          end else if (32'(q_item_i.slot) >= TABLE_DEPTH) begin
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.status      = ST_SLOT_EMPTY;
            out_d.slot_index  = q_item_i.slot;
            out_d.total_bytes = OUT_W'(total_q);
          end else begin
            state_d = S_AGE_RD;
          end
        end
      end

      // Issue one read a cycle, compare the word read the cycle before
      S_SCAN: begin
        if (!hit_q && (iss_q < (IW+1)'(TABLE_DEPTH))) begin
          iss_d     = iss_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = iss_q[IW-1:0];
        end
        if (cmp_vld_q && !hit_q) begin
          if (ram_rdata.valid) begin
            if (ram_rdata.addresses == item_q.key_addr &&
                ram_rdata.proto_ports == item_q.key_pp) begin
              hit_d     = 1'b1;
              hit_idx_d = cmp_idx_q;
              word_d    = ram_rdata;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
        end
        if (hit_q || (iss_q == (IW+1)'(TABLE_DEPTH) && !cmp_vld_q)) begin
          state_d = S_PKT;
        end
      end

      S_PKT: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        out_d       = '0;
        if (hit_q) begin
          nw.bytes   = flow_new;
          nw.packets = (word_q.packets == 16'hFFFF) ? word_q.packets
                                                    : word_q.packets + 16'd1;
          ram_we     = 1'b1;
          ram_waddr  = hit_idx_q;
          ram_wdata  = nw;
          total_d    = total_new;
          out_d.status           = ST_COUNTED;
          out_d.slot_index       = 10'(hit_idx_q);
          out_d.interval_packets = nw.packets;
          out_d.flow_bytes       = OUT_W'(flow_new);
          out_d.total_bytes      = OUT_W'(total_new);
        end else if (32'(flow_cnt_q) >= 32'(cfg_i.flow_limit) || !free_q) begin
          out_d.status      = ST_TABLE_FULL;
          out_d.total_bytes = OUT_W'(total_q);
        end else begin
          nw.valid       = 1'b1;
          nw.started     = 1'b0;
          nw.idle        = cfg_i.idle_reload;
          nw.packets     = 16'd1;
          nw.average     = '0;
          nw.prev_bytes  = '0;
          nw.bytes       = len;
          nw.proto_ports = item_q.key_pp;
          nw.addresses   = item_q.key_addr;
          ram_we         = 1'b1;
          ram_waddr      = free_idx_q;
          ram_wdata      = nw;
          flow_cnt_d     = flow_cnt_q + 1'b1;
          total_d        = total_new;
          out_d.status           = ST_NEW_FLOW;
          out_d.slot_index       = 10'(free_idx_q);
          out_d.interval_packets = 16'd1;
          out_d.flow_bytes       = OUT_W'(len);
          out_d.total_bytes      = OUT_W'(total_new);
        end
      end

      // Entry word is on the read port; take the byte delta
      S_AGE_RD: begin
        word_d  = ram_rdata;
        delta_d = (ram_rdata.bytes > ram_rdata.prev_bytes) ?
                  ram_rdata.bytes - ram_rdata.prev_bytes : '0;
        if (ram_rdata.valid) begin
          state_d = S_AGE;
        end else begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status      = ST_SLOT_EMPTY;
          out_d.slot_index  = item_q.slot;
          out_d.total_bytes = OUT_W'(total_q);
        end
      end

      // Close the interval, update average and idle count, free if idle
      S_AGE: begin
        nw.prev_bytes = word_q.bytes;
        nw.packets    = 16'd0;
        nw.started    = 1'b1;
        nw.average    = avg_new;
        nw.valid      = !freed;
        if (nz) begin
          nw.idle = cfg_i.idle_reload;
        end else if (!freed) begin
          nw.idle = word_q.idle - 3'd1;
        end
        ram_we    = 1'b1;
        ram_waddr = IW'(item_q.slot);
        ram_wdata = nw;
        if (freed && flow_cnt_q != '0) begin
          flow_cnt_d = flow_cnt_q - 1'b1;
        end
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        out_d.status           = freed ? ST_AGED_FREED : ST_AGED_KEPT;
        out_d.slot_index       = item_q.slot;
        out_d.interval_rate    = OUT_W'(delta_q);
        out_d.average_rate     = OUT_W'(avg_new);
        out_d.interval_packets = nz ? word_q.packets : 16'd0;
        out_d.flow_bytes       = OUT_W'(word_q.bytes);
        out_d.total_bytes      = OUT_W'(total_q);
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      iss_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      flow_cnt_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      flow_cnt_q  <= flow_cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    word_q     <= word_d;
    delta_q    <= delta_d;
    out_q      <= out_d;
  end

endmodule

>>> src/flow_rate_meter_table_core.sv
// ----------------------------------------------------------------------------
// flow_rate_meter_table_core
// Per-flow byte and packet meter with table allocation and interval aging.
//
//   Channel   Dir  Beat carries
//   s_axis    in   tuser op, tdata packet/age item
//   m_axis    out  tuser status, tdata one result per item
//   apb       in   register writes and reads
//
// A packet item scans the table one slot a cycle through the RAM read port:
// on a miss every slot is read before the next beat is taken; an early
// hit ends the scan at the matching slot.
// An age item steps through read, update and write-back, result and
// release; a slot beyond the table is answered without a table read.
// After reset every slot of the table is swept free; no beat is
// taken from the input queue during that sweep.
// A two-beat queue decouples input from the table; a held result stalls
// only the table side.
// ----------------------------------------------------------------------------
module flow_rate_meter_table_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // protocol, src_addr, sport, dst_addr, dport, packet_bytes, slot
  input  logic [frmt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot_index, interval_rate, average_rate, interval_packets,
  // flow_bytes, total_bytes
  output logic [frmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [2:0]                      m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import frmt_pkg::*;

  frmt_cfg_t    cfg_q;
  logic         q_valid, q_ready;
  frmt_item_t   q_item;
  frmt_result_t res;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_only <= 1'b0;
      cfg_q.flow_limit  <= 11'd1024;
      cfg_q.idle_reload <= 3'd6;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SOURCE_ONLY: cfg_q.source_only <= pwdata[0];
        REG_FLOW_LIMIT:  cfg_q.flow_limit  <= pwdata[10:0];
        REG_IDLE_RELOAD: cfg_q.idle_reload <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_SOURCE_ONLY: prdata = {31'd0, cfg_q.source_only};
      REG_FLOW_LIMIT:  prdata = {21'd0, cfg_q.flow_limit};
      REG_IDLE_RELOAD: prdata = {29'd0, cfg_q.idle_reload};
      default:         prdata = 32'd0;
    endcase
  end

  frmt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .in_op_i           (s_axis_tuser[0]),
    .in_protocol_i     (s_axis_tdata[7:0]),
    .in_src_addr_i     (s_axis_tdata[39:8]),
    .in_sport_i        (s_axis_tdata[55:40]),
    .in_dst_addr_i     (s_axis_tdata[87:56]),
    .in_dport_i        (s_axis_tdata[103:88]),
    .in_packet_bytes_i (s_axis_tdata[119:104]),
    .in_slot_i         (s_axis_tdata[129:120]),
    .q_valid_o         (q_valid),
    .q_ready_i         (q_ready),
    .q_item_o          (q_item)
  );

  frmt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Pack the result beat
  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {6'd0, res.total_bytes, res.flow_bytes, res.interval_packets,
                         res.average_rate, res.interval_rate, res.slot_index};

endmodule

>>> src/frmt_checker.sv
// ----------------------------------------------------------------------------
// frmt_checker
// Port-level checks of the flow rate meter result stream.
// ----------------------------------------------------------------------------
`include "flow_rate_meter_table_core_macros.svh"

module frmt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [frmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]                      m_axis_tuser
);
  import frmt_pkg::*;

  // A stalled result beat holds
  `FRMT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed")

  // Dropped packets report no slot and no flow bytes
  `FRMT_ASSERT_IMP(a_full_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_TABLE_FULL,
    m_axis_tdata[9:0] == 10'd0 && m_axis_tdata[169:122] == 48'd0, "full beat not zeroed")

  // Packet results carry no rates
  `FRMT_ASSERT_IMP(a_pkt_rate, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == ST_COUNTED || m_axis_tuser == ST_NEW_FLOW),
    m_axis_tdata[105:10] == 96'd0, "packet beat with rate")

  // A new flow starts with one packet
  `FRMT_ASSERT_IMP(a_new_one, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_NEW_FLOW,
    m_axis_tdata[121:106] == 16'd1, "new flow packet count")

endmodule

bind flow_rate_meter_table_core frmt_checker u_frmt_checker (.*);
